@@ rtl/tds_pkg.sv @@
// Package for the task dependency scoreboard.
// Holds sizes, status and opcode codes, and the per-slot control struct.
// No dependencies.
package tds_pkg;

  localparam int MaxTasks = 32;
  localparam int MaxDeps = 8;
  localparam int PeerBits = 8;
  localparam int IdxW = $clog2(MaxTasks);
  localparam int DepW = $clog2(MaxDeps);

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_READY    = 2'd1,
    ST_ASSIGNED = 2'd2,
    ST_DONE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_DEFINE   = 3'd0,
    OP_LOAD     = 3'd1,
    OP_LIST     = 3'd2,
    OP_ASSIGN   = 3'd3,
    OP_COMPLETE = 3'd4,
    OP_REASSIGN = 3'd5,
    OP_QUERY    = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_WALK  = 2'd1,
    FSM_LIST  = 2'd2,
    FSM_COUNT = 2'd3
  } fsm_e;

  // Command broadcast to the row of cells for one cycle.
  typedef struct packed {
    logic              define;
    logic              load;
    logic              assign_t;
    logic              reassign;
    logic              complete;
    logic              walk;
    logic [IdxW-1:0]   idx;
    logic [3:0]        total;
    logic [DepW-1:0]   slot;
    logic [4:0]        dep_task;
    logic [PeerBits-1:0] peer;
  } cell_cmd_t;

endpackage

@@ rtl/tds_cell.sv @@
// One task slot of the scoreboard: status, counts, peer and dependency list.
// Depends on tds_pkg.
module tds_cell
  import tds_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] my_idx_i,
  input  cell_cmd_t       cmd_i,
  input  logic            active_i,
  input  logic [5:0]      cnt_i,
  output logic [5:0]      cnt_o,
  output status_e         status_o
);

  status_e             status_q, status_d;
  logic [3:0]          needed_q, needed_d;
  logic [3:0]          sat_q, sat_d;
  logic [PeerBits-1:0] peer_q, peer_d;
  logic [5:0]          cnt_q, cnt_d;
  logic [4:0]          list_q [MaxDeps];
  logic                sel;
  logic                hit;

  assign sel = (cmd_i.idx == my_idx_i);
  assign status_o = status_q;
  assign cnt_d = cnt_i + {5'd0, (active_i && status_q == ST_READY)};
  assign cnt_o = cnt_q;

  always_comb begin
    hit = 1'b0;
    for (int d = 0; d < MaxDeps; d++) begin
      if ((d < 32'(needed_q)) && (list_q[d] == cmd_i.dep_task)) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    status_d = status_q;
    needed_d = needed_q;
    sat_d = sat_q;
    peer_d = peer_q;
    if (cmd_i.define && sel) begin
      needed_d = cmd_i.total;
      sat_d = '0;
      status_d = (cmd_i.total == 4'd0) ? ST_READY : ST_PENDING;
    end
    if (cmd_i.assign_t && sel) begin
      peer_d = cmd_i.peer;
      status_d = ST_ASSIGNED;
    end
    if (cmd_i.reassign && sel) begin
      peer_d = '0;
      status_d = ST_READY;
    end
    if (cmd_i.complete && sel) begin
      status_d = ST_DONE;
    end
    if (cmd_i.walk && active_i && status_q == ST_PENDING) begin
      if (hit && sat_q != 4'd15) begin
        sat_d = sat_q + 4'd1;
      end
      if (((hit && sat_q != 4'd15) ? sat_q + 4'd1 : sat_q) == needed_q) begin
        status_d = ST_READY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_PENDING;
      needed_q <= '0;
      sat_q <= '0;
      peer_q <= '0;
      cnt_q <= '0;
    end else begin
      status_q <= status_d;
      needed_q <= needed_d;
      sat_q <= sat_d;
      peer_q <= peer_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && sel) begin
      list_q[cmd_i.slot] <= cmd_i.dep_task;
    end
  end

endmodule

@@ rtl/task_dependency_scoreboard.sv @@
// Top level of the task dependency scoreboard: command decode, row of slot
// cells, completion walk and ready listing. Depends on tds_pkg and tds_cell.
//
// Define, load, assign, reassign, query and rejected commands give their one
// result in the cycle after the accepting edge. Complete first moves to the walk
// state, which updates every slot in use in parallel and registers the result. A
// listing first lets the ready count pass through the row of cells, one cell
// per cycle, in the count state, and then scans one slot per cycle in the list
// state until the last ready slot, or the one empty result, has been sent.
// busy is high until the final result is registered. Each result is shown for
// one cycle with res_valid_o; the receiver cannot stall it.
module task_dependency_scoreboard
  import tds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [4:0]  task_index_i,
  input  logic [3:0]  dep_total_i,
  input  logic [2:0]  dep_slot_i,
  input  logic [4:0]  dep_task_i,
  input  logic [7:0]  peer_index_i,
  output logic        res_valid_o,
  output logic        error_o,
  output logic        task_valid_o,
  output logic [4:0]  ready_task_o,
  output logic [5:0]  ready_count_o,
  output logic        last_o,
  output logic [5:0]  done_count_o,
  output logic        all_done_o
);

  logic [5:0]      task_count_q;
  logic [5:0]      comp_q;
  fsm_e            state_q, state_d;
  logic [5:0]      n_used;
  logic [IdxW:0]   ptr_q, ptr_d;
  logic [5:0]      total_q, total_d;
  logic [5:0]      sent_q, sent_d;
  cell_cmd_t       cmd;
  logic [5:0]      chain [MaxTasks+1];
  status_e         stat [MaxTasks];
  logic            acc, inrange;
  logic            rv_d, err_d, tv_d, last_d;
  logic [4:0]      rt_d;
  logic [5:0]      rc_d;
  logic            comp_inc;
  logic [IdxW-1:0] ptr_idx;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {26'd0, task_count_q} : 32'd0;
  assign acc = start && !busy;
  assign busy = (state_q != FSM_IDLE);
  assign n_used = (task_count_q < 6'(MaxTasks)) ? task_count_q : 6'(MaxTasks);
  assign inrange = {1'b0, task_index_i} < n_used;
  assign ptr_idx = ptr_q[IdxW-1:0];

  assign chain[0] = '0;
  for (genvar g = 0; g < MaxTasks; g++) begin : g_cells
    tds_cell u_cell (
      .clk_i,
      .rst_ni,
      .my_idx_i (IdxW'(g)),
      .cmd_i    (cmd),
      .active_i (6'(g) < n_used),
      .cnt_i    (chain[g]),
      .cnt_o    (chain[g+1]),
      .status_o (stat[g])
    );
  end

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q;
    total_d = total_q;
    sent_d = sent_q;
    cmd = '0;
    cmd.dep_task = dep_task_i;
    cmd.idx = task_index_i;
    cmd.total = dep_total_i;
    cmd.slot = dep_slot_i;
    cmd.peer = peer_index_i;
    comp_inc = 1'b0;
    rv_d = 1'b0;
    err_d = 1'b0;
    tv_d = 1'b0;
    rt_d = '0;
    rc_d = '0;
    last_d = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        if (acc) begin
          rv_d = 1'b1;
          last_d = 1'b1;
          case (opcode_i)
            OP_DEFINE: begin
              err_d = !inrange || dep_total_i > 4'(MaxDeps);
              cmd.define = !err_d;
            end
            OP_LOAD: begin
              err_d = !inrange;
              cmd.load = !err_d;
            end
            OP_ASSIGN: begin
              err_d = !inrange || stat[task_index_i] != ST_READY;
              cmd.assign_t = !err_d;
            end
            OP_REASSIGN: begin
              err_d = !inrange || stat[task_index_i] != ST_ASSIGNED;
              cmd.reassign = !err_d;
            end
            OP_COMPLETE: begin
              err_d = !inrange;
              cmd.complete = !err_d;
              comp_inc = !err_d;
              rv_d = err_d;
              if (!err_d) begin
                state_d = FSM_WALK;
                total_d = {1'b0, task_index_i};
              end
            end
            OP_LIST: begin
              rv_d = 1'b0;
              last_d = 1'b0;
              state_d = FSM_COUNT;
              ptr_d = '0;
              sent_d = '0;
            end
            OP_QUERY: err_d = 1'b0;
            default: err_d = 1'b1;
          endcase
        end
      end
      FSM_WALK: begin
        cmd.walk = 1'b1;
        cmd.dep_task = total_q[4:0];
        state_d = FSM_IDLE;
        rv_d = 1'b1;
        last_d = 1'b1;
      end
      FSM_COUNT: begin
        if (ptr_q == (IdxW+1)'(MaxTasks)) begin
          total_d = chain[MaxTasks];
          ptr_d = '0;
          state_d = FSM_LIST;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      FSM_LIST: begin
        if (total_q == 6'd0) begin
          rv_d = 1'b1;
          last_d = 1'b1;
          state_d = FSM_IDLE;
        end else begin
          if ((ptr_q < {1'b0, n_used[IdxW-1:0]} || n_used == 6'(MaxTasks))
              && stat[ptr_idx] == ST_READY) begin
            rv_d = 1'b1;
            tv_d = 1'b1;
            rt_d = 5'(ptr_idx);
            rc_d = total_q;
            sent_d = sent_q + 6'd1;
            last_d = (sent_q + 6'd1 == total_q);
          end
          ptr_d = ptr_q + 1'b1;
          if (last_d) begin
            state_d = FSM_IDLE;
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      task_count_q <= 6'd32;
      comp_q <= '0;
      ptr_q <= '0;
      total_q <= '0;
      sent_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q <= ptr_d;
      total_q <= total_d;
      sent_q <= sent_d;
      res_valid_o <= rv_d;
      if (psel && penable && pwrite && paddr == 2'd0) begin
        task_count_q <= pwdata[5:0];
      end
      if (comp_inc && comp_q != 6'd63) begin
        comp_q <= comp_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    error_o <= err_d;
    task_valid_o <= tv_d;
    ready_task_o <= rt_d;
    ready_count_o <= rc_d;
    last_o <= last_d;
  end

  assign done_count_o = comp_q;
  assign all_done_o = (comp_q == task_count_q);

endmodule

@@ sim/task_dependency_scoreboard_test.sv @@
// Self-checking testbench for task_dependency_scoreboard, a task slot table with
// dependency counting. It depends on tds_pkg and the block's RTL, and checks every
// result strobe against a cycle-free prediction built from the accepted commands.
`timescale 1ns / 1ps

module task_dependency_scoreboard_test;
  import tds_pkg::*;

  typedef struct {
    logic [2:0] op;
    logic [4:0] idx;
    logic [3:0] total;
    logic [2:0] slot;
    logic [4:0] dtask;
    logic [7:0] peer;
    int         gap;
    bit         drain;
  } cmd_t;

  typedef struct {
    logic       err;
    logic       valid;
    logic [4:0] task_id;
    logic [5:0] cnt;
    logic       last;
    logic [5:0] done;
    logic       alld;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode_i = '0;
  logic [4:0]  task_index_i = '0;
  logic [3:0]  dep_total_i = '0;
  logic [2:0]  dep_slot_i = '0;
  logic [4:0]  dep_task_i = '0;
  logic [7:0]  peer_index_i = '0;
  logic        res_valid_o, error_o, task_valid_o, last_o, all_done_o;
  logic [4:0]  ready_task_o;
  logic [5:0]  ready_count_o, done_count_o;

  task_dependency_scoreboard i_dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  cmd_t pending_cmds[$];
  res_t expected_res[$];
  int   mismatches = 0;
  int   cmds_sent = 0;
  int   results_seen = 0;
  int   lists_seen = 0;

  // Mirror of the scoreboard state.
  status_e    m_status[MaxTasks];
  logic [3:0] m_needed[MaxTasks];
  logic [3:0] m_sat[MaxTasks];
  logic [4:0] m_deps[MaxTasks][MaxDeps];
  logic [7:0] m_peer[MaxTasks];
  logic [5:0] m_done;
  logic [5:0] m_count;

  // Generation-side record of which dependency entries have been loaded.
  bit written[MaxTasks][MaxDeps];

  function automatic void push_res(logic err, logic valid, logic [4:0] t, logic [5:0] c,
                                   logic last);
    res_t r;
    r.err = err; r.valid = valid; r.task_id = t; r.cnt = c; r.last = last;
    r.done = m_done;
    r.alld = (m_done == m_count);
    expected_res.push_back(r);
  endfunction

  function automatic void predict(cmd_t c);
    int n;
    int cnt;
    int k;
    bit inr;
    logic err;
    n = (m_count < MaxTasks) ? m_count : MaxTasks;
    inr = c.idx < n;
    err = 1'b0;
    if (c.op == OP_LIST) begin
      cnt = 0;
      for (int i = 0; i < n; i++) if (m_status[i] == ST_READY) cnt++;
      if (cnt == 0) begin
        push_res(1'b0, 1'b0, '0, '0, 1'b1);
      end else begin
        k = 0;
        for (int i = 0; i < n; i++) begin
          if (m_status[i] == ST_READY) begin
            k++;
            push_res(1'b0, 1'b1, i[4:0], cnt[5:0], k == cnt);
          end
        end
      end
      return;
    end
    case (c.op)
      OP_DEFINE: begin
        if (!inr || c.total > MaxDeps) err = 1'b1;
        else begin
          m_needed[c.idx] = c.total;
          m_sat[c.idx] = '0;
          m_status[c.idx] = (c.total == 0) ? ST_READY : ST_PENDING;
        end
      end
      OP_LOAD: begin
        if (!inr || c.slot >= MaxDeps) err = 1'b1;
        else m_deps[c.idx][c.slot] = c.dtask;
      end
      OP_ASSIGN: begin
        if (!inr || m_status[c.idx] != ST_READY) err = 1'b1;
        else begin
          m_peer[c.idx] = c.peer;
          m_status[c.idx] = ST_ASSIGNED;
        end
      end
      OP_COMPLETE: begin
        if (!inr) err = 1'b1;
        else begin
          m_status[c.idx] = ST_DONE;
          if (m_done < 63) m_done++;
          for (int i = 0; i < n; i++) begin
            if (m_status[i] == ST_PENDING) begin
              for (int d = 0; d < m_needed[i] && d < MaxDeps; d++) begin
                if (m_deps[i][d] == c.idx) begin
                  if (m_sat[i] < 15) m_sat[i]++;
                  break;
                end
              end
              if (m_sat[i] == m_needed[i]) m_status[i] = ST_READY;
            end
          end
        end
      end
      OP_REASSIGN: begin
        if (!inr || m_status[c.idx] != ST_ASSIGNED) err = 1'b1;
        else begin
          m_peer[c.idx] = '0;
          m_status[c.idx] = ST_READY;
        end
      end
      OP_QUERY: ;
      default: err = 1'b1;
    endcase
    push_res(err, 1'b0, '0, '0, 1'b1);
  endfunction

  function automatic void add_cmd(logic [2:0] op, logic [4:0] idx, logic [3:0] total,
                                  logic [2:0] slot, logic [4:0] dtask, logic [7:0] peer,
                                  int n);
    cmd_t c;
    c.op = op; c.idx = idx; c.total = total; c.slot = slot; c.dtask = dtask;
    c.peer = peer;
    c.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    c.drain = ($urandom_range(0, 40) == 0);
    if (op == OP_LOAD && idx < n) written[idx][slot] = 1'b1;
    pending_cmds.push_back(c);
  endfunction

  // A define in range first loads every list position it will make visible that is not yet loaded.
  function automatic void add_define(logic [4:0] idx, logic [3:0] total, int n, int dep_hi);
    if (idx < n && total <= MaxDeps) begin
      for (int d = 0; d < total; d++) begin
        if (!written[idx][d])
          add_cmd(OP_LOAD, idx, $urandom, d[2:0], $urandom_range(0, dep_hi), $urandom, n);
      end
    end
    add_cmd(OP_DEFINE, idx, total, $urandom, $urandom, $urandom, n);
  endfunction

  function automatic void add_job(int n);
    int k;
    int nd;
    k = $urandom_range(1, (n < 8) ? n : 8);
    for (int j = 0; j < k; j++) begin
      nd = (j == 0) ? 0 : $urandom_range(0, (j < MaxDeps) ? j : MaxDeps);
      for (int d = 0; d < nd; d++)
        add_cmd(OP_LOAD, j[4:0], $urandom, d[2:0], $urandom_range(0, j - 1), $urandom, n);
      add_cmd(OP_DEFINE, j[4:0], nd[3:0], $urandom, $urandom, $urandom, n);
    end
    for (int j = 0; j < k; j++) begin
      if ($urandom_range(0, 2) == 0) add_cmd(OP_LIST, $urandom, $urandom, $urandom,
                                             $urandom, $urandom, n);
      add_cmd(OP_ASSIGN, j[4:0], $urandom, $urandom, $urandom, $urandom, n);
      if ($urandom_range(0, 3) == 0) begin
        add_cmd(OP_REASSIGN, j[4:0], $urandom, $urandom, $urandom, $urandom, n);
        add_cmd(OP_ASSIGN, j[4:0], $urandom, $urandom, $urandom, $urandom, n);
      end
      add_cmd(OP_COMPLETE, j[4:0], $urandom, $urandom, $urandom, $urandom, n);
    end
    add_cmd(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, n);
  endfunction

  function automatic void add_noise(int n);
    logic [4:0] idx;
    int pick;
    idx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, n - 1);
    pick = $urandom_range(0, 99);
    if (pick < 15) add_define(idx, ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 8),
                              n, 31);
    else if (pick < 25) add_cmd(OP_LOAD, idx, $urandom, $urandom, $urandom, $urandom, n);
    else if (pick < 40) add_cmd(OP_LIST, $urandom, $urandom, $urandom, $urandom, $urandom, n);
    else if (pick < 55) add_cmd(OP_ASSIGN, idx, $urandom, $urandom, $urandom, $urandom, n);
    else if (pick < 75) add_cmd(OP_COMPLETE, idx, $urandom, $urandom, $urandom, $urandom, n);
    else if (pick < 88) add_cmd(OP_REASSIGN, idx, $urandom, $urandom, $urandom, $urandom, n);
    else if (pick < 95) add_cmd(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, n);
    else add_cmd(3'd7, $urandom, $urandom, $urandom, $urandom, $urandom, n);
  endfunction

  // Driver: presents queued commands, with random gaps and occasional drains.
  always @(posedge clk_i) begin
    if (rst_ni && !(start && busy)) begin
      if (start) begin
        predict(pending_cmds.pop_front());
        cmds_sent++;
      end
      if (pending_cmds.size() > 0 && pending_cmds[0].gap > 0) begin
        pending_cmds[0].gap--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0 &&
                   (!pending_cmds[0].drain || (!start && !busy && expected_res.size() == 0))) begin
        start        <= 1'b1;
        opcode_i     <= pending_cmds[0].op;
        task_index_i <= pending_cmds[0].idx;
        dep_total_i  <= pending_cmds[0].total;
        dep_slot_i   <= pending_cmds[0].slot;
        dep_task_i   <= pending_cmds[0].dtask;
        peer_index_i <= pending_cmds[0].peer;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compares every strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: task %0d", ready_task_o);
      end else begin
        e = expected_res.pop_front();
        if (e.valid && e.last) lists_seen++;
        if (error_o !== e.err || task_valid_o !== e.valid || ready_task_o !== e.task_id ||
            ready_count_o !== e.cnt || last_o !== e.last || done_count_o !== e.done ||
            all_done_o !== e.alld) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp err %0d val %0d task %0d cnt %0d last %0d done %0d all %0d, got err %0d val %0d task %0d cnt %0d last %0d done %0d all %0d",
                     e.err, e.valid, e.task_id, e.cnt, e.last, e.done, e.alld,
                     error_o, task_valid_o, ready_task_o, ready_count_o, last_o,
                     done_count_o, all_done_o);
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start || busy || expected_res.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_count(logic [5:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= {26'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    m_count = v;
    @(posedge clk_i);
  endtask

  initial begin
    int counts[5] = '{32, 1, 32, 0, 5};
    int n;
    for (int i = 0; i < MaxTasks; i++) begin
      m_status[i] = ST_PENDING; m_needed[i] = '0; m_sat[i] = '0; m_peer[i] = '0;
    end
    m_done = '0;
    m_count = 6'd32;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset width of 32 slots.
    n = 32;
    add_cmd(OP_LIST, 0, 0, 0, 0, 0, n);
    add_cmd(OP_QUERY, 31, 15, 7, 31, 255, n);
    add_cmd(OP_ASSIGN, 3, 0, 0, 0, 0, n);
    add_cmd(OP_REASSIGN, 3, 0, 0, 0, 0, n);
    add_cmd(OP_DEFINE, 2, 9, 0, 0, 0, n);
    add_cmd(OP_DEFINE, 2, 15, 0, 0, 0, n);
    add_define(31, 8, n, 31);
    add_cmd(OP_DEFINE, 0, 0, 0, 0, 0, n);
    add_cmd(OP_ASSIGN, 0, 0, 0, 0, 255, n);
    add_cmd(OP_REASSIGN, 0, 0, 0, 0, 0, n);
    add_cmd(OP_ASSIGN, 0, 0, 0, 0, 0, n);
    add_cmd(OP_COMPLETE, 0, 0, 0, 0, 0, n);
    add_cmd(OP_COMPLETE, 0, 0, 0, 0, 0, n);
    add_cmd(OP_LIST, 0, 0, 0, 0, 0, n);
    add_cmd(3'd7, 31, 15, 7, 31, 255, n);
    add_cmd(OP_LOAD, 31, 0, 7, 31, 0, n);
    add_cmd(OP_COMPLETE, 31, 0, 0, 0, 0, n);
    pending_cmds[pending_cmds.size() - 1].drain = 1'b1;
    wait_idle();
    write_count(6'd32);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      n = (counts[p] == 0) ? $urandom_range(2, 31) : counts[p];
      write_count(n[5:0]);
      if (p == 1) begin
        add_cmd(OP_DEFINE, 1, 0, 0, 0, 0, n);
        add_cmd(OP_COMPLETE, 31, 0, 0, 0, 0, n);
      end
      while (pending_cmds.size() < 80) begin
        if ($urandom_range(0, 2) == 0) add_noise(n);
        else add_job(n);
      end
    end
    wait_idle();
    $display("Sent %0d commands across six task_count settings; checked %0d result transactions.",
             cmds_sent, results_seen);
    $display("Listings with ready tasks: %0d, final completion count %0d.", lists_seen, m_done);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout.");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
